// File: src/sum_tree_sampler_core_macros.svh
// ----------------------------------------------------------------------------
// sum tree sampler assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef SUM_TREE_SAMPLER_CORE_MACROS_SVH
`define SUM_TREE_SAMPLER_CORE_MACROS_SVH

// condition holds at every edge outside reset
`define STS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define STS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the cycle after the antecedent
`define STS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sum tree sampler package
// field widths, command codes and controller/datapath handshake structs
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int LEVELS_DEFAULT   = 10;

   localparam int ITEM_W   = 32;
   localparam int WEIGHT_W = 24;
   localparam int SUM_W    = 34;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic clear_step;
      logic item_write;
      logic leaf_write;
      logic up_step;
      logic total_capture;
      logic desc_step;
      logic rsp_load;
   } sts_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic at_root;
      logic last_inner;
      logic rsp_free;
   } sts_status_type;

endpackage

// File: src/sts_if.sv
// ----------------------------------------------------------------------------
// sum tree sampler channels
// request and response valid/ready channels with their payloads
// ----------------------------------------------------------------------------
interface sts_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [sts_pkg::ITEM_W-1:0]   item;
   logic [sts_pkg::WEIGHT_W-1:0] weight;
   logic [sts_pkg::SUM_W-1:0]    search_value;

   modport source (output valid, command, item, weight, search_value, input ready);
   modport sink   (input valid, command, item, weight, search_value, output ready);
endinterface

interface sts_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [sts_pkg::ITEM_W-1:0] found_item;
   logic [sts_pkg::SUM_W-1:0]  remainder;
   logic [sts_pkg::SUM_W-1:0]  total_weight;
   logic                      out_of_range;

   modport source (output valid, found_item, remainder, total_weight, out_of_range,
                   input ready);
   modport sink   (input valid, found_item, remainder, total_weight, out_of_range,
                   output ready);
endinterface

// File: src/sum_tree_sampler_core.sv
// ----------------------------------------------------------------------------
// sum tree sampler core
// ring-buffered sum tree: appends walk leaf to root, samples walk root to leaf
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents
//  ----------+-----+-----------------------------------------------------------
//  req_chan  | in  | command, item, weight, search_value
//  rsp_chan  | out | found_item, remainder, total_weight, out_of_range
//
//  an append reads and writes the node memory once per tree level, a sample
//  reads it once per tree level; both walks are paced by these accesses,
//  with the registered read of the node memory in the loop
//  after reset all 2^(LEVELS+1)-1 nodes of the node memory are zeroed, one
//  node per cycle, and req_chan.ready stays low meanwhile
//  a finished beat waits in the response register; the next request is
//  accepted while it waits, and only the hand-over of a new result stalls
// ----------------------------------------------------------------------------
module sum_tree_sampler_core #(
   parameter int CAPACITY = sts_pkg::CAPACITY_DEFAULT,
   parameter int LEVELS   = sts_pkg::LEVELS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   sts_req_if.sink   req_chan,
   sts_rsp_if.source rsp_chan
);

   // command and status between sequencer and datapath
   sts_pkg::sts_cmd_type    cmd;
   sts_pkg::sts_status_type status;

   // sequencer: clearing pass, update walk, descent, response hand-over
   sts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .status   (status),
      .cmd      (cmd)
   );

   // node sums, item store, walk index and response register
   sts_datapath #(
      .CAPACITY (CAPACITY),
      .LEVELS   (LEVELS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// File: src/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sum tree sampler controller
// sequences clearing, leaf-to-root updates and root-to-leaf descents
// ----------------------------------------------------------------------------
`include "sum_tree_sampler_core_macros.svh"

module sts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   sts_req_if.sink                 req_chan,
   input  sts_pkg::sts_status_type status,
   output sts_pkg::sts_cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b00_0000_0001,
      S_IDLE    = 10'b00_0000_0010,
      S_A_READ  = 10'b00_0000_0100,
      S_A_LEAF  = 10'b00_0000_1000,
      S_A_UP    = 10'b00_0001_0000,
      S_S_ROOT  = 10'b00_0010_0000,
      S_S_TOTAL = 10'b00_0100_0000,
      S_S_DESC  = 10'b00_1000_0000,
      S_S_ITEM  = 10'b01_0000_0000,
      S_DONE    = 10'b10_0000_0000
   } sts_state_type;

   sts_state_type state_ff, state_in;

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd.load_req = 1'b1;
               state_in = (req_chan.command == sts_pkg::CMD_SAMPLE) ? S_S_ROOT : S_A_READ;
            end
         end
         S_A_READ: begin
            cmd.item_write = 1'b1;
            state_in = S_A_LEAF;
         end
         S_A_LEAF: begin
            cmd.leaf_write = 1'b1;
            state_in = S_A_UP;
         end
         S_A_UP: begin
            cmd.up_step = 1'b1;
            if (status.at_root) state_in = S_DONE;
         end
         S_S_ROOT: begin
            state_in = S_S_TOTAL;
         end
         S_S_TOTAL: begin
            cmd.total_capture = 1'b1;
            state_in = S_S_DESC;
         end
         S_S_DESC: begin
            cmd.desc_step = 1'b1;
            if (status.last_inner) state_in = S_S_ITEM;
         end
         S_S_ITEM: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `STS_ASSERT_NEXT(a_load_starts_op, clock, reset, cmd.load_req,
      state_ff == S_A_READ || state_ff == S_S_ROOT,
      "accepted beat did not start an operation")
   `STS_ASSERT_NEXT(a_desc_ends_at_leaf, clock, reset,
      state_ff == S_S_DESC && status.last_inner, state_ff == S_S_ITEM,
      "descent overran the leaf level")
   `STS_ASSERT_NEXT(a_up_ends_at_root, clock, reset,
      state_ff == S_A_UP && status.at_root, state_ff == S_DONE,
      "update walk passed the root")

endmodule

// File: src/sts_datapath.sv
// ----------------------------------------------------------------------------
// sum tree sampler datapath
// node sum and item memories, walk index, remainder and response registers
// ----------------------------------------------------------------------------
`include "sum_tree_sampler_core_macros.svh"

module sts_datapath #(
   parameter int CAPACITY = sts_pkg::CAPACITY_DEFAULT,
   parameter int LEVELS   = sts_pkg::LEVELS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   sts_req_if.sink                  req_chan,
   sts_rsp_if.source                rsp_chan,
   input  sts_pkg::sts_cmd_type     cmd,
   output sts_pkg::sts_status_type  status
);

   localparam int NODE_AW    = LEVELS + 1;
   localparam int NODES      = (2 ** (LEVELS + 1)) - 1;
   localparam int LEAVES     = 2 ** LEVELS;
   localparam int LEAF_BASE  = LEAVES - 1;
   localparam int INNER_LAST = (2 ** (LEVELS - 1)) - 1;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int WIDE_W     = (SLOT_W > LEVELS) ? SLOT_W : LEVELS;
   localparam int SUM_W      = sts_pkg::SUM_W;
   localparam int ITEM_W     = sts_pkg::ITEM_W;
   localparam int WEIGHT_W   = sts_pkg::WEIGHT_W;

   // storage
   logic [SUM_W-1:0]  node_sums_ff  [NODES];
   logic [ITEM_W-1:0] item_store_ff [LEAVES];
   logic [SUM_W-1:0]  node_q_ff;
   logic [ITEM_W-1:0] item_q_ff;

   // control registers
   logic [NODE_AW-1:0] clr_ff, clr_in;
   logic [NODE_AW-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                cmd_ff, cmd_in;
   logic [ITEM_W-1:0]   item_ff, item_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [SUM_W-1:0]    value_ff, value_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    diff_ff, diff_in;
   logic [SUM_W-1:0]    total_ff, total_in;
   logic                oor_ff, oor_in;
   logic [ITEM_W-1:0]   found_ff, found_in;
   logic [SUM_W-1:0]    rsp_rem_ff, rsp_rem_in;
   logic [SUM_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                rsp_oor_ff, rsp_oor_in;

   // address arithmetic
   logic [WIDE_W-1:0]  slot_wide;
   logic [LEVELS-1:0]  leaf_slot;
   logic [NODE_AW-1:0] leaf_node;
   logic [NODE_AW-1:0] parent_idx;
   logic [NODE_AW-1:0] left_idx;
   logic [NODE_AW-1:0] desc_idx;
   logic [NODE_AW-1:0] idx_plus;
   logic [LEVELS-1:0]  item_rd_addr;
   logic [NODE_AW-1:0] node_rd_addr;
   logic               node_we;
   logic [NODE_AW-1:0] node_wa;
   logic [SUM_W-1:0]   node_wd;
   logic [SUM_W-1:0]   up_sum;
   logic               go_right;
   logic               rsp_free;

   assign slot_wide    = WIDE_W'(slot_ff);
   assign leaf_slot    = slot_wide[LEVELS-1:0];
   assign leaf_node    = NODE_AW'(leaf_slot) + NODE_AW'(LEAF_BASE);
   assign parent_idx   = (idx_ff - NODE_AW'(1)) >> 1;
   assign left_idx     = {idx_ff[LEVELS-1:0], 1'b1};
   assign go_right     = (rem_ff >= node_q_ff);
   assign desc_idx     = go_right ? (left_idx + NODE_AW'(1)) : left_idx;
   assign idx_plus     = idx_ff + NODE_AW'(1);
   assign item_rd_addr = idx_plus[LEVELS-1:0];
   assign up_sum       = node_q_ff + diff_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_chan.ready;

   assign status.clear_last = (clr_ff == NODE_AW'(NODES - 1));
   assign status.at_root    = (idx_ff == '0);
   assign status.last_inner = (idx_ff >= NODE_AW'(INNER_LAST));
   assign status.rsp_free   = rsp_free;

   // node memory ports
   always_comb begin
      if (cmd.leaf_write || cmd.up_step) begin
         node_rd_addr = parent_idx;
      end else if (cmd.total_capture) begin
         node_rd_addr = left_idx;
      end else if (cmd.desc_step && !status.last_inner) begin
         node_rd_addr = {desc_idx[LEVELS-1:0], 1'b1};
      end else begin
         node_rd_addr = idx_ff;
      end
      node_we = cmd.clear_step || cmd.leaf_write || cmd.up_step;
      node_wa = cmd.clear_step ? clr_ff : idx_ff;
      if (cmd.clear_step) begin
         node_wd = '0;
      end else if (cmd.leaf_write) begin
         node_wd = SUM_W'(weight_ff);
      end else begin
         node_wd = up_sum;
      end
   end

   always_ff @(posedge clock) begin
      node_q_ff <= node_sums_ff[node_rd_addr];
      if (node_we) node_sums_ff[node_wa] <= node_wd;
   end

   always_ff @(posedge clock) begin
      item_q_ff <= item_store_ff[item_rd_addr];
      if (cmd.item_write) item_store_ff[leaf_slot] <= item_ff;
   end

   // next values
   always_comb begin
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      cmd_in       = cmd_ff;
      item_in      = item_ff;
      weight_in    = weight_ff;
      value_in     = value_ff;
      rem_in       = rem_ff;
      diff_in      = diff_ff;
      total_in     = total_ff;
      oor_in       = oor_ff;
      found_in     = found_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_total_in = rsp_total_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (cmd.clear_step) clr_in = clr_ff + NODE_AW'(1);

      if (cmd.load_req) begin
         cmd_in    = req_chan.command;
         item_in   = req_chan.item;
         weight_in = req_chan.weight;
         value_in  = req_chan.search_value;
         rem_in    = req_chan.search_value;
         idx_in    = (req_chan.command == sts_pkg::CMD_SAMPLE) ? '0 : leaf_node;
      end

      if (cmd.leaf_write) begin
         diff_in = SUM_W'(weight_ff) - node_q_ff;
         idx_in  = parent_idx;
      end

      if (cmd.up_step) begin
         idx_in = parent_idx;
         if (status.at_root) begin
            total_in = up_sum;
            slot_in  = (slot_ff == SLOT_W'(CAPACITY - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end
      end

      if (cmd.total_capture) begin
         total_in = node_q_ff;
         oor_in   = (value_ff >= node_q_ff);
      end

      if (cmd.desc_step) begin
         idx_in = desc_idx;
         rem_in = go_right ? (rem_ff - node_q_ff) : rem_ff;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_total_in = total_ff;
         if (cmd_ff == sts_pkg::CMD_SAMPLE) begin
            found_in   = item_q_ff;
            rsp_rem_in = rem_ff;
            rsp_oor_in = oor_ff;
         end else begin
            found_in   = '0;
            rsp_rem_in = '0;
            rsp_oor_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         idx_ff       <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         idx_ff       <= idx_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      item_ff      <= item_in;
      weight_ff    <= weight_in;
      value_ff     <= value_in;
      rem_ff       <= rem_in;
      diff_ff      <= diff_in;
      total_ff     <= total_in;
      oor_ff       <= oor_in;
      found_ff     <= found_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_total_ff <= rsp_total_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found_item   = found_ff;
   assign rsp_chan.remainder    = rsp_rem_ff;
   assign rsp_chan.total_weight = rsp_total_ff;
   assign rsp_chan.out_of_range = rsp_oor_ff;

   `STS_ASSERT_ALWAYS(a_idx_in_tree, clock, reset, idx_ff <= NODE_AW'(NODES - 1),
      "walk index left the tree")
   `STS_ASSERT_IMPLIES(a_load_only_when_free, clock, reset, cmd.rsp_load, rsp_free,
      "response register overwritten before it was taken")
   `STS_ASSERT_NEXT(a_rem_never_grows, clock, reset, cmd.desc_step,
      rem_ff <= $past(rem_ff), "remainder grew during descent")

endmodule
